FILE: rtl/trc_pkg.sv
// Package for the triangle circumcircle pipeline: field widths, fixed constants
// and the side-data records that travel beside the divider and square-root stages.
// No dependencies.
package trc_pkg;

    // Coordinate and intermediate widths
    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;        // vertex offset from A
    localparam int PROD_W   = 2 * DIFF_W;         // offset products
    localparam int DET_W    = PROD_W + 2;         // doubled determinant, signed
    localparam int DMAG_W   = DET_W - 1;          // determinant magnitude
    localparam int NORM_W   = 33;                 // squared offset length
    localparam int NPROD_W  = NORM_W + 1 + DIFF_W; // numerator partial products
    localparam int NUMS_W   = NPROD_W + 1;        // signed numerator
    localparam int NUM_W    = NUMS_W - 1;         // numerator magnitude, quotient
    localparam int DEN_W    = DMAG_W;             // divisor
    localparam int QR_W     = NUM_W + 1;          // rounded quotient

    // Offset clip at 2^40
    localparam int OFS_SHIFT = 40;
    localparam int OFS_W     = OFS_SHIFT + 1;
    localparam logic [QR_W-1:0] OFS_LIMIT = QR_W'(1) << OFS_SHIFT;

    // Centroid: floor((2|s| + 3) / 6) by reciprocal multiply
    localparam int SUM_W       = COORD_W + 2;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP = 20'd699051;
    localparam int CPROD_W     = SUM_W + RECIP_W;
    localparam int CENT_W      = 16;

    // Square root
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int SQREM_W = ROOT_W + 2;

    // Outputs and register
    localparam int OUT_W = 32;
    localparam int THR_W = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd1;
    localparam logic [OUT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_MIN = 32'h8000_0000;
    localparam logic [OUT_W-1:0] RAD_MAX = 32'hFFFF_FFFF;

    // Data carried beside the divider stages
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic                      col;
        logic signed [OUT_W-1:0]   cent_x;
        logic signed [OUT_W-1:0]   cent_y;
        logic                      neg_x;
        logic                      neg_y;
    } div_side_t;

    // Data carried beside the square-root stages
    typedef struct packed {
        logic [OUT_W-1:0] ox;
        logic [OUT_W-1:0] oy;
        logic             col;
        logic             sat_c;
        logic             ovf;
    } sq_side_t;

endpackage

FILE: rtl/trc_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on trc_pkg for the numerator and divisor widths.
module trc_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [trc_pkg::NUM_W-1:0] num,
    input  logic [trc_pkg::DEN_W-1:0] den,
    output logic [trc_pkg::NUM_W-1:0] quo,
    output logic [trc_pkg::DEN_W-1:0] rem,
    output logic [trc_pkg::DEN_W-1:0] den_out
);

    logic [trc_pkg::NUM_W-1:0] acc_reg  [trc_pkg::NUM_W];
    logic [trc_pkg::NUM_W-1:0] acc_cur  [trc_pkg::NUM_W];
    logic [trc_pkg::NUM_W-1:0] acc_next [trc_pkg::NUM_W];
    logic [trc_pkg::DEN_W-1:0] rem_reg  [trc_pkg::NUM_W];
    logic [trc_pkg::DEN_W-1:0] rem_cur  [trc_pkg::NUM_W];
    logic [trc_pkg::DEN_W-1:0] rem_next [trc_pkg::NUM_W];
    logic [trc_pkg::DEN_W-1:0] den_reg  [trc_pkg::NUM_W];
    logic [trc_pkg::DEN_W-1:0] den_cur  [trc_pkg::NUM_W];

    // Select each stage's operands
    always_comb
    begin
        acc_cur[0] = num;
        rem_cur[0] = '0;
        den_cur[0] = den;
        for (int i = 1; i < trc_pkg::NUM_W; i++)
        begin
            acc_cur[i] = acc_reg[i-1];
            rem_cur[i] = rem_reg[i-1];
            den_cur[i] = den_reg[i-1];
        end
    end

    // Shift in one numerator bit, subtract when it fits, shift in the quotient bit
    always_comb
    begin
        logic [trc_pkg::DEN_W:0] trial;
        logic [trc_pkg::DEN_W:0] diff;
        for (int i = 0; i < trc_pkg::NUM_W; i++)
        begin
            trial = {rem_cur[i], acc_cur[i][trc_pkg::NUM_W-1]};
            diff  = trial - {1'b0, den_cur[i]};
            if (trial >= {1'b0, den_cur[i]})
            begin
                rem_next[i] = diff[trc_pkg::DEN_W-1:0];
                acc_next[i] = {acc_cur[i][trc_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[trc_pkg::DEN_W-1:0];
                acc_next[i] = {acc_cur[i][trc_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < trc_pkg::NUM_W; i++)
            begin
                acc_reg[i] <= acc_next[i];
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_cur[i];
            end
        end
    end

    assign quo     = acc_reg[trc_pkg::NUM_W-1];
    assign rem     = rem_reg[trc_pkg::NUM_W-1];
    assign den_out = den_reg[trc_pkg::NUM_W-1];

endmodule

FILE: rtl/trc_sqrt.sv
// Pipelined integer square root: one root bit per register stage, remainder kept.
// Depends on trc_pkg for the radicand and root widths.
module trc_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [trc_pkg::RAD_W-1:0]   rad_in,
    output logic [trc_pkg::ROOT_W-1:0]  root_out,
    output logic [trc_pkg::SQREM_W-1:0] rem_out
);

    logic [trc_pkg::RAD_W-1:0]   rad_reg   [trc_pkg::ROOT_W];
    logic [trc_pkg::RAD_W-1:0]   rad_cur   [trc_pkg::ROOT_W];
    logic [trc_pkg::ROOT_W-1:0]  root_reg  [trc_pkg::ROOT_W];
    logic [trc_pkg::ROOT_W-1:0]  root_cur  [trc_pkg::ROOT_W];
    logic [trc_pkg::ROOT_W-1:0]  root_next [trc_pkg::ROOT_W];
    logic [trc_pkg::SQREM_W-1:0] rem_reg   [trc_pkg::ROOT_W];
    logic [trc_pkg::SQREM_W-1:0] rem_cur   [trc_pkg::ROOT_W];
    logic [trc_pkg::SQREM_W-1:0] rem_next  [trc_pkg::ROOT_W];

    // Select each stage's operands
    always_comb
    begin
        rad_cur[0]  = rad_in;
        root_cur[0] = '0;
        rem_cur[0]  = '0;
        for (int i = 1; i < trc_pkg::ROOT_W; i++)
        begin
            rad_cur[i]  = rad_reg[i-1];
            root_cur[i] = root_reg[i-1];
            rem_cur[i]  = rem_reg[i-1];
        end
    end

    // Bring down two radicand bits, try 4*root+1
    always_comb
    begin
        logic [trc_pkg::SQREM_W+1:0] part;
        logic [trc_pkg::SQREM_W+1:0] trial;
        logic [trc_pkg::SQREM_W+1:0] diff;
        for (int i = 0; i < trc_pkg::ROOT_W; i++)
        begin
            part  = {rem_cur[i], rad_cur[i][trc_pkg::RAD_W-1 -: 2]};
            trial = {2'b00, root_cur[i], 2'b01};
            diff  = part - trial;
            if (part >= trial)
            begin
                rem_next[i]  = diff[trc_pkg::SQREM_W-1:0];
                root_next[i] = {root_cur[i][trc_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = part[trc_pkg::SQREM_W-1:0];
                root_next[i] = {root_cur[i][trc_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < trc_pkg::ROOT_W; i++)
            begin
                rad_reg[i]  <= rad_cur[i] << 2;
                root_reg[i] <= root_next[i];
                rem_reg[i]  <= rem_next[i];
            end
        end
    end

    assign root_out = root_reg[trc_pkg::ROOT_W-1];
    assign rem_out  = rem_reg[trc_pkg::ROOT_W-1];

endmodule

FILE: rtl/triangle_circumcircle_top.sv
// Pipeline from an input transfer to the output: 6 setup stages, 51 divider stages,
// 5 rounding and squaring stages, 32 root stages, and the output register.
// Throughput: one triangle per cycle while the pipeline is not stalled; every stage advances
// together and the output register lets the pipeline fill while a result waits.
// Reset: asynchronous active low; clears all valid bits, threshold returns to 1.
module triangle_circumcircle_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // ax, ay, bx, by, cx, cy (16 bits each)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // center_x, center_y, radius (32 bits each)
    output logic [1:0]  m_axis_tuser,   // collinear, saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // collinear_threshold
);

    localparam int CW = trc_pkg::COORD_W;
    localparam int DW = trc_pkg::DIFF_W;
    localparam int PW = trc_pkg::PROD_W;
    localparam int NW = trc_pkg::NUM_W;
    localparam int RW = trc_pkg::ROOT_W;
    localparam int OW = trc_pkg::OUT_W;

    logic adv;
    logic v_last;
    logic [trc_pkg::THR_W-1:0] thr_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= trc_pkg::THR_RESET;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // Input fields
    logic signed [CW-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    assign in_ax = s_axis_tdata[15:0];
    assign in_ay = s_axis_tdata[31:16];
    assign in_bx = s_axis_tdata[47:32];
    assign in_by = s_axis_tdata[63:48];
    assign in_cx = s_axis_tdata[79:64];
    assign in_cy = s_axis_tdata[95:80];

    // Stall the pipeline only when the output holds an untaken result and the last stage is full
    assign adv           = m_axis_tready || !m_axis_tvalid || !v_last;
    assign s_axis_tready = adv;

    // Valid bits of the setup and post stages
    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg, p6_v_reg;
    logic p7_v_reg, p8_v_reg, p9_v_reg, p10_v_reg, p11_v_reg;
    logic dv_v_reg [NW];
    logic sq_v_reg [RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            p5_v_reg  <= 1'b0;
            p6_v_reg  <= 1'b0;
            p7_v_reg  <= 1'b0;
            p8_v_reg  <= 1'b0;
            p9_v_reg  <= 1'b0;
            p10_v_reg <= 1'b0;
            p11_v_reg <= 1'b0;
            for (int i = 0; i < NW; i++)
                dv_v_reg[i] <= 1'b0;
            for (int i = 0; i < RW; i++)
                sq_v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg <= s_axis_tvalid;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            p5_v_reg <= p4_v_reg;
            p6_v_reg <= p5_v_reg;
            dv_v_reg[0] <= p6_v_reg;
            for (int i = 1; i < NW; i++)
                dv_v_reg[i] <= dv_v_reg[i-1];
            p7_v_reg  <= dv_v_reg[NW-1];
            p8_v_reg  <= p7_v_reg;
            p9_v_reg  <= p8_v_reg;
            p10_v_reg <= p9_v_reg;
            p11_v_reg <= p10_v_reg;
            sq_v_reg[0] <= p11_v_reg;
            for (int i = 1; i < RW; i++)
                sq_v_reg[i] <= sq_v_reg[i-1];
        end
    end

    assign v_last = sq_v_reg[RW-1];

    // Stage 1: offsets from A and coordinate sums
    logic signed [CW-1:0] p1_ax_reg, p1_ay_reg;
    logic signed [DW-1:0] p1_bx_reg, p1_by_reg, p1_cx_reg, p1_cy_reg;
    logic signed [trc_pkg::SUM_W-1:0] p1_sx_reg, p1_sy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_ax_reg <= in_ax;
            p1_ay_reg <= in_ay;
            p1_bx_reg <= $signed({in_bx[CW-1], in_bx}) - $signed({in_ax[CW-1], in_ax});
            p1_by_reg <= $signed({in_by[CW-1], in_by}) - $signed({in_ay[CW-1], in_ay});
            p1_cx_reg <= $signed({in_cx[CW-1], in_cx}) - $signed({in_ax[CW-1], in_ax});
            p1_cy_reg <= $signed({in_cy[CW-1], in_cy}) - $signed({in_ay[CW-1], in_ay});
            p1_sx_reg <= $signed({{2{in_ax[CW-1]}}, in_ax}) + $signed({{2{in_bx[CW-1]}}, in_bx})
                       + $signed({{2{in_cx[CW-1]}}, in_cx});
            p1_sy_reg <= $signed({{2{in_ay[CW-1]}}, in_ay}) + $signed({{2{in_by[CW-1]}}, in_by})
                       + $signed({{2{in_cy[CW-1]}}, in_cy});
        end
    end

    // Stage 2: cross and square products, centroid dividend
    logic signed [CW-1:0] p2_ax_reg, p2_ay_reg;
    logic signed [DW-1:0] p2_bx_reg, p2_by_reg, p2_cx_reg, p2_cy_reg;
    logic signed [PW-1:0] p2_bxcy_reg, p2_bycx_reg;
    logic signed [PW-1:0] p2_bbx_reg, p2_bby_reg, p2_ccx_reg, p2_ccy_reg;
    logic [trc_pkg::SUM_W-1:0] p2_cmx_reg, p2_cmy_reg;
    logic p2_cnx_reg, p2_cny_reg;
    logic [trc_pkg::SUM_W-1:0] sx_abs, sy_abs;

    assign sx_abs = p1_sx_reg[trc_pkg::SUM_W-1] ? -p1_sx_reg : p1_sx_reg;
    assign sy_abs = p1_sy_reg[trc_pkg::SUM_W-1] ? -p1_sy_reg : p1_sy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_ax_reg   <= p1_ax_reg;
            p2_ay_reg   <= p1_ay_reg;
            p2_bx_reg   <= p1_bx_reg;
            p2_by_reg   <= p1_by_reg;
            p2_cx_reg   <= p1_cx_reg;
            p2_cy_reg   <= p1_cy_reg;
            p2_bxcy_reg <= p1_bx_reg * p1_cy_reg;
            p2_bycx_reg <= p1_by_reg * p1_cx_reg;
            p2_bbx_reg  <= p1_bx_reg * p1_bx_reg;
            p2_bby_reg  <= p1_by_reg * p1_by_reg;
            p2_ccx_reg  <= p1_cx_reg * p1_cx_reg;
            p2_ccy_reg  <= p1_cy_reg * p1_cy_reg;
            p2_cmx_reg  <= {sx_abs[trc_pkg::SUM_W-2:0], 1'b0} + trc_pkg::SUM_W'(3);
            p2_cmy_reg  <= {sy_abs[trc_pkg::SUM_W-2:0], 1'b0} + trc_pkg::SUM_W'(3);
            p2_cnx_reg  <= p1_sx_reg[trc_pkg::SUM_W-1];
            p2_cny_reg  <= p1_sy_reg[trc_pkg::SUM_W-1];
        end
    end

    // Stage 3: doubled determinant, squared lengths, centroid reciprocal multiply
    logic signed [CW-1:0] p3_ax_reg, p3_ay_reg;
    logic signed [DW-1:0] p3_bx_reg, p3_by_reg, p3_cx_reg, p3_cy_reg;
    logic signed [trc_pkg::DET_W-1:0] p3_d_reg;
    logic [trc_pkg::NORM_W-1:0] p3_b2_reg, p3_c2_reg;
    logic [trc_pkg::CPROD_W-1:0] p3_cpx_reg, p3_cpy_reg;
    logic p3_cnx_reg, p3_cny_reg;
    logic signed [PW:0] det_half;
    logic [PW-1:0] b2_full, c2_full;

    assign det_half = $signed({p2_bxcy_reg[PW-1], p2_bxcy_reg})
                    - $signed({p2_bycx_reg[PW-1], p2_bycx_reg});
    assign b2_full  = p2_bbx_reg + p2_bby_reg;
    assign c2_full  = p2_ccx_reg + p2_ccy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_ax_reg  <= p2_ax_reg;
            p3_ay_reg  <= p2_ay_reg;
            p3_bx_reg  <= p2_bx_reg;
            p3_by_reg  <= p2_by_reg;
            p3_cx_reg  <= p2_cx_reg;
            p3_cy_reg  <= p2_cy_reg;
            p3_d_reg   <= {det_half, 1'b0};
            p3_b2_reg  <= b2_full[trc_pkg::NORM_W-1:0];
            p3_c2_reg  <= c2_full[trc_pkg::NORM_W-1:0];
            p3_cpx_reg <= p2_cmx_reg * trc_pkg::RECIP;
            p3_cpy_reg <= p2_cmy_reg * trc_pkg::RECIP;
            p3_cnx_reg <= p2_cnx_reg;
            p3_cny_reg <= p2_cny_reg;
        end
    end

    // Stage 4: numerator products, determinant magnitude, signed centroid
    logic signed [CW-1:0] p4_ax_reg, p4_ay_reg;
    logic signed [trc_pkg::NPROD_W-1:0] p4_bcy_reg, p4_cby_reg, p4_cbx_reg, p4_bcx_reg;
    logic [trc_pkg::DMAG_W-1:0] p4_dmag_reg;
    logic p4_dneg_reg, p4_dzero_reg;
    logic signed [OW-1:0] p4_centx_reg, p4_centy_reg;
    logic [trc_pkg::DET_W-1:0] d_abs;
    logic signed [OW-1:0] qcx, qcy;

    assign d_abs = p3_d_reg[trc_pkg::DET_W-1] ? -p3_d_reg : p3_d_reg;
    assign qcx   = {16'b0, p3_cpx_reg[trc_pkg::RECIP_SHIFT +: trc_pkg::CENT_W]};
    assign qcy   = {16'b0, p3_cpy_reg[trc_pkg::RECIP_SHIFT +: trc_pkg::CENT_W]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_ax_reg    <= p3_ax_reg;
            p4_ay_reg    <= p3_ay_reg;
            p4_bcy_reg   <= $signed({1'b0, p3_b2_reg}) * p3_cy_reg;
            p4_cby_reg   <= $signed({1'b0, p3_c2_reg}) * p3_by_reg;
            p4_cbx_reg   <= $signed({1'b0, p3_c2_reg}) * p3_bx_reg;
            p4_bcx_reg   <= $signed({1'b0, p3_b2_reg}) * p3_cx_reg;
            p4_dmag_reg  <= d_abs[trc_pkg::DMAG_W-1:0];
            p4_dneg_reg  <= p3_d_reg[trc_pkg::DET_W-1];
            p4_dzero_reg <= (p3_d_reg == '0);
            p4_centx_reg <= p3_cnx_reg ? -qcx : qcx;
            p4_centy_reg <= p3_cny_reg ? -qcy : qcy;
        end
    end

    // Stage 5: numerators and collinear test
    logic signed [CW-1:0] p5_ax_reg, p5_ay_reg;
    logic signed [trc_pkg::NUMS_W-1:0] p5_nx_reg, p5_ny_reg;
    logic [trc_pkg::DMAG_W-1:0] p5_dmag_reg;
    logic p5_dneg_reg, p5_col_reg;
    logic signed [OW-1:0] p5_centx_reg, p5_centy_reg;
    localparam int NP = trc_pkg::NPROD_W;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_ax_reg    <= p4_ax_reg;
            p5_ay_reg    <= p4_ay_reg;
            p5_nx_reg    <= $signed({p4_bcy_reg[NP-1], p4_bcy_reg})
                          - $signed({p4_cby_reg[NP-1], p4_cby_reg});
            p5_ny_reg    <= $signed({p4_cbx_reg[NP-1], p4_cbx_reg})
                          - $signed({p4_bcx_reg[NP-1], p4_bcx_reg});
            p5_dmag_reg  <= p4_dmag_reg;
            p5_dneg_reg  <= p4_dneg_reg;
            p5_col_reg   <= p4_dzero_reg
                         || (p4_dmag_reg < {{(trc_pkg::DMAG_W-trc_pkg::THR_W){1'b0}}, thr_reg});
            p5_centx_reg <= p4_centx_reg;
            p5_centy_reg <= p4_centy_reg;
        end
    end

    // Stage 6: numerator magnitudes and quotient signs
    logic [NW-1:0] p6_nmx_reg, p6_nmy_reg;
    logic [trc_pkg::DEN_W-1:0] p6_dmag_reg;
    trc_pkg::div_side_t p6_side_reg;
    logic [trc_pkg::NUMS_W-1:0] nx_abs, ny_abs;

    assign nx_abs = p5_nx_reg[trc_pkg::NUMS_W-1] ? -p5_nx_reg : p5_nx_reg;
    assign ny_abs = p5_ny_reg[trc_pkg::NUMS_W-1] ? -p5_ny_reg : p5_ny_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_nmx_reg         <= nx_abs[NW-1:0];
            p6_nmy_reg         <= ny_abs[NW-1:0];
            p6_dmag_reg        <= p5_dmag_reg;
            p6_side_reg.ax     <= p5_ax_reg;
            p6_side_reg.ay     <= p5_ay_reg;
            p6_side_reg.col    <= p5_col_reg;
            p6_side_reg.cent_x <= p5_centx_reg;
            p6_side_reg.cent_y <= p5_centy_reg;
            p6_side_reg.neg_x  <= p5_nx_reg[trc_pkg::NUMS_W-1] ^ p5_dneg_reg;
            p6_side_reg.neg_y  <= p5_ny_reg[trc_pkg::NUMS_W-1] ^ p5_dneg_reg;
        end
    end

    // Divider stages
    logic [NW-1:0] qx, qy;
    logic [trc_pkg::DEN_W-1:0] remx, remy, denx, deny;
    trc_pkg::div_side_t dv_side_reg [NW];

    trc_div u_div_x (
        .clk     (clk),
        .en      (adv),
        .num     (p6_nmx_reg),
        .den     (p6_dmag_reg),
        .quo     (qx),
        .rem     (remx),
        .den_out (denx)
    );

    trc_div u_div_y (
        .clk     (clk),
        .en      (adv),
        .num     (p6_nmy_reg),
        .den     (p6_dmag_reg),
        .quo     (qy),
        .rem     (remy),
        .den_out (deny)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= p6_side_reg;
            for (int i = 1; i < NW; i++)
                dv_side_reg[i] <= dv_side_reg[i-1];
        end
    end

    // Stage 7: round half away from zero
    logic [trc_pkg::QR_W-1:0] p7_qx_reg, p7_qy_reg;
    trc_pkg::div_side_t p7_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p7_qx_reg   <= {1'b0, qx}
                         + trc_pkg::QR_W'({remx, 1'b0} >= {1'b0, denx});
            p7_qy_reg   <= {1'b0, qy}
                         + trc_pkg::QR_W'({remy, 1'b0} >= {1'b0, deny});
            p7_side_reg <= dv_side_reg[NW-1];
        end
    end

    // Stage 8: clip offset magnitude
    logic [trc_pkg::OFS_W-1:0] p8_qx_reg, p8_qy_reg;
    trc_pkg::div_side_t p8_side_reg;
    logic [trc_pkg::QR_W-1:0] qx_clip, qy_clip;

    assign qx_clip = (p7_qx_reg > trc_pkg::OFS_LIMIT) ? trc_pkg::OFS_LIMIT : p7_qx_reg;
    assign qy_clip = (p7_qy_reg > trc_pkg::OFS_LIMIT) ? trc_pkg::OFS_LIMIT : p7_qy_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p8_qx_reg   <= qx_clip[trc_pkg::OFS_W-1:0];
            p8_qy_reg   <= qy_clip[trc_pkg::OFS_W-1:0];
            p8_side_reg <= p7_side_reg;
        end
    end

    // Stage 9: apply sign, flag offsets too large to square
    logic signed [trc_pkg::OFS_W:0] p9_rx_reg, p9_ry_reg;
    logic [OW-1:0] p9_mx_reg, p9_my_reg;
    logic p9_big_reg;
    trc_pkg::div_side_t p9_side_reg;
    logic signed [trc_pkg::OFS_W:0] qx_s, qy_s;

    assign qx_s = $signed({1'b0, p8_qx_reg});
    assign qy_s = $signed({1'b0, p8_qy_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p9_rx_reg   <= p8_side_reg.neg_x ? -qx_s : qx_s;
            p9_ry_reg   <= p8_side_reg.neg_y ? -qy_s : qy_s;
            p9_mx_reg   <= p8_qx_reg[OW-1:0];
            p9_my_reg   <= p8_qy_reg[OW-1:0];
            p9_big_reg  <= (|p8_qx_reg[trc_pkg::OFS_W-1:OW])
                         || (|p8_qy_reg[trc_pkg::OFS_W-1:OW]);
            p9_side_reg <= p8_side_reg;
        end
    end

    // Stage 10: center with saturation, squared offsets
    localparam int CTR_W = trc_pkg::OFS_W + 2;
    logic [OW-1:0] p10_ox_reg, p10_oy_reg;
    logic [2*OW-1:0] p10_sxx_reg, p10_syy_reg;
    logic p10_col_reg, p10_satc_reg, p10_big_reg;
    logic signed [CTR_W-1:0] ox_full, oy_full;
    logic ox_sat, oy_sat;
    logic [OW-1:0] ox_clip, oy_clip;

    assign ox_full = $signed({{(CTR_W-CW){p9_side_reg.ax[CW-1]}}, p9_side_reg.ax})
                   + $signed({p9_rx_reg[trc_pkg::OFS_W], p9_rx_reg});
    assign oy_full = $signed({{(CTR_W-CW){p9_side_reg.ay[CW-1]}}, p9_side_reg.ay})
                   + $signed({p9_ry_reg[trc_pkg::OFS_W], p9_ry_reg});
    assign ox_sat  = !((&ox_full[CTR_W-1:OW-1]) || !(|ox_full[CTR_W-1:OW-1]));
    assign oy_sat  = !((&oy_full[CTR_W-1:OW-1]) || !(|oy_full[CTR_W-1:OW-1]));
    assign ox_clip = ox_sat ? (ox_full[CTR_W-1] ? trc_pkg::NEG_MIN : trc_pkg::POS_MAX)
                            : ox_full[OW-1:0];
    assign oy_clip = oy_sat ? (oy_full[CTR_W-1] ? trc_pkg::NEG_MIN : trc_pkg::POS_MAX)
                            : oy_full[OW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p10_ox_reg   <= p9_side_reg.col ? p9_side_reg.cent_x : ox_clip;
            p10_oy_reg   <= p9_side_reg.col ? p9_side_reg.cent_y : oy_clip;
            p10_sxx_reg  <= p9_mx_reg * p9_mx_reg;
            p10_syy_reg  <= p9_my_reg * p9_my_reg;
            p10_col_reg  <= p9_side_reg.col;
            p10_satc_reg <= !p9_side_reg.col && (ox_sat || oy_sat);
            p10_big_reg  <= p9_big_reg;
        end
    end

    // Stage 11: squared radius and its overflow
    logic [trc_pkg::RAD_W-1:0] p11_s_reg;
    trc_pkg::sq_side_t p11_side_reg;
    logic [trc_pkg::RAD_W:0] s_full;

    assign s_full = {1'b0, p10_sxx_reg} + {1'b0, p10_syy_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p11_s_reg          <= s_full[trc_pkg::RAD_W-1:0];
            p11_side_reg.ox    <= p10_ox_reg;
            p11_side_reg.oy    <= p10_oy_reg;
            p11_side_reg.col   <= p10_col_reg;
            p11_side_reg.sat_c <= p10_satc_reg;
            p11_side_reg.ovf   <= p10_big_reg || s_full[trc_pkg::RAD_W];
        end
    end

    // Square-root stages
    logic [RW-1:0] root;
    logic [trc_pkg::SQREM_W-1:0] root_rem;
    trc_pkg::sq_side_t sq_side_reg [RW];

    trc_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .rad_in   (p11_s_reg),
        .root_out (root),
        .rem_out  (root_rem)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= p11_side_reg;
            for (int i = 1; i < RW; i++)
                sq_side_reg[i] <= sq_side_reg[i-1];
        end
    end

    // Round the root to nearest and assemble the result
    trc_pkg::sq_side_t sq_fin;
    logic rnd_up, root_sat;
    logic [OW-1:0] root_rnd, rad_fin;
    logic sat_fin;

    assign sq_fin   = sq_side_reg[RW-1];
    assign rnd_up   = root_rem > {2'b00, root};
    assign root_rnd = root + OW'(rnd_up);
    assign root_sat = rnd_up && (&root);
    assign rad_fin  = sq_fin.col ? '0
                    : ((sq_fin.ovf || root_sat) ? trc_pkg::RAD_MAX : root_rnd);
    assign sat_fin  = !sq_fin.col && (sq_fin.sat_c || sq_fin.ovf || root_sat);

    // Output register: load when empty or the held result transfers
    logic out_v_reg;
    logic [95:0] out_data_reg;
    logic [1:0]  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (m_axis_tready || !out_v_reg)
            out_v_reg <= v_last;
    end

    always_ff @(posedge clk)
    begin
        if (m_axis_tready || !out_v_reg)
        begin
            out_data_reg <= {rad_fin, sq_fin.oy, sq_fin.ox};
            out_user_reg <= {sat_fin, sq_fin.col};
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

FILE: rtl/trc_chk.sv
// Port-level checker for the triangle circumcircle top level, with its bind.
// Depends only on the top level's ports.
module trc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // Collinear results carry zero radius and no saturation
    a_col_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[95:64] == 32'd0
        && !m_axis_tuser[1]))
        else $error("collinear result with radius or saturation");

    // Saturation shows as a clipped value somewhere
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata[31:0] == 32'h7FFF_FFFF
        || m_axis_tdata[31:0] == 32'h8000_0000 || m_axis_tdata[63:32] == 32'h7FFF_FFFF
        || m_axis_tdata[63:32] == 32'h8000_0000 || m_axis_tdata[95:64] == 32'hFFFF_FFFF))
        else $error("saturated flag without a clipped value");

    // An empty output never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid
        && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind triangle_circumcircle_top trc_chk u_trc_chk (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for triangle_circumcircle_top: a stream driver and a
// result monitor compare every output with an in-line circumcircle predictor.
// Depends on trc_pkg and triangle_circumcircle_top.
module tb_top;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 20000;

    typedef struct {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [31:0]        radius;
        logic               collinear;
        logic               saturated;
    } circle_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    logic [95:0]     triangles_pending[$];
    circle_t         circles_expected[$];
    logic [trc_pkg::THR_W-1:0] threshold;
    int              errors;
    int              in_gap;
    int              out_gap;
    int              stall_cycles;
    bit              no_idle;
    logic            s_axis_tready_seen;

    triangle_circumcircle_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Free-running clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Rounded quotient of two magnitudes, clipped at 2^40
    function automatic longint round_quot(logic [127:0] num, logic [63:0] den);
        logic [127:0] q;
        logic [127:0] r;
        q = num / den;
        r = num % den;
        if (q > 128'(trc_pkg::OFS_LIMIT))
            return longint'(trc_pkg::OFS_LIMIT);
        if (2 * r >= den)
            q = q + 1;
        if (q > 128'(trc_pkg::OFS_LIMIT))
            q = 128'(trc_pkg::OFS_LIMIT);
        return longint'(q);
    endfunction

    // Signed division rounded half away from zero
    function automatic longint offset_div(logic signed [127:0] num, longint den);
        logic [127:0] un;
        logic [63:0]  ud;
        longint       q;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q  = round_quot(un, ud);
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    // Centroid coordinate: sum / 3 rounded half away from zero
    function automatic longint centroid_third(longint s);
        longint q;
        q = ((s < 0 ? -s : s) * 2 + 3) / 6;
        return s < 0 ? -q : q;
    endfunction

    function automatic logic signed [31:0] clip32(longint v, ref logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return trc_pkg::POS_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return trc_pkg::NEG_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Predict the circumcircle of one triangle
    function automatic circle_t circumcircle(logic [95:0] v,
                                             logic [trc_pkg::THR_W-1:0] thr);
        circle_t            c;
        longint             ax, ay, bx, by, cx, cy, d, dm, rx, ry, b2, c2;
        logic signed [127:0] nx, ny;
        logic [63:0]        mx, my, sx, sy, f;
        logic [64:0]        s;
        logic               sat;
        ax = longint'(signed'(v[15:0]));
        ay = longint'(signed'(v[31:16]));
        bx = longint'(signed'(v[47:32])) - ax;
        by = longint'(signed'(v[63:48])) - ay;
        cx = longint'(signed'(v[79:64])) - ax;
        cy = longint'(signed'(v[95:80])) - ay;
        d  = 2 * (bx * cy - by * cx);
        dm = d < 0 ? -d : d;
        sat = 1'b0;
        c.radius = 0;
        c.collinear = (d == 0) || (dm < longint'(thr));
        if (c.collinear)
        begin
            c.center_x = 32'(centroid_third(3 * ax + bx + cx));
            c.center_y = 32'(centroid_third(3 * ay + by + cy));
        end
        else
        begin
            b2 = bx * bx + by * by;
            c2 = cx * cx + cy * cy;
            nx = 128'(b2) * 128'(cy) - 128'(c2) * 128'(by);
            ny = 128'(c2) * 128'(bx) - 128'(b2) * 128'(cx);
            rx = offset_div(nx, d);
            ry = offset_div(ny, d);
            c.center_x = clip32(ax + rx, sat);
            c.center_y = clip32(ay + ry, sat);
            mx = rx < 0 ? -rx : rx;
            my = ry < 0 ? -ry : ry;
            if (mx >= 64'h1_0000_0000 || my >= 64'h1_0000_0000)
            begin
                c.radius = trc_pkg::RAD_MAX;
                sat = 1'b1;
            end
            else
            begin
                sx = mx * mx;
                sy = my * my;
                s  = 65'(sx) + 65'(sy);
                if (s[64])
                begin
                    c.radius = trc_pkg::RAD_MAX;
                    sat = 1'b1;
                end
                else
                begin
                    f = int_sqrt(s[63:0]);
                    if (s[63:0] > f * f + f)
                        f = f + 1;
                    if (f > 64'(trc_pkg::RAD_MAX))
                    begin
                        f = 64'(trc_pkg::RAD_MAX);
                        sat = 1'b1;
                    end
                    c.radius = f[31:0];
                end
            end
        end
        c.saturated = sat;
        return c;
    endfunction

    function automatic int pick_gap();
        int k;
        if (no_idle)
            return 0;
        k = $urandom_range(0, 19);
        if (k < 11)
            return 0;
        if (k < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Input driver: advance to the next triangle once the current one transfers
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            in_gap        <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready_seen)
        begin
            if (in_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                in_gap        <= in_gap - 1;
            end
            else if (triangles_pending.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= triangles_pending.pop_front();
                in_gap        <= pick_gap();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Output backpressure
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_gap       <= 0;
        end
        else if (out_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            out_gap       <= out_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            out_gap       <= pick_gap();
        end
    end

    // Record input transfers, predict, and check output transfers
    always @(posedge clk or negedge rst_n)
    begin
        circle_t want;
        if (!rst_n)
        begin
            s_axis_tready_seen <= 1'b0;
            stall_cycles       <= 0;
        end
        else
        begin
            s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                circles_expected.push_back(circumcircle(s_axis_tdata, threshold));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (circles_expected.size() == 0)
                begin
                    $error("unexpected result transfer: tdata=%h tuser=%b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = circles_expected.pop_front();
                    if (m_axis_tdata[31:0] !== want.center_x)
                    begin
                        $error("center_x: expected %0d, got %0d", want.center_x,
                               $signed(m_axis_tdata[31:0]));
                        errors++;
                    end
                    if (m_axis_tdata[63:32] !== want.center_y)
                    begin
                        $error("center_y: expected %0d, got %0d", want.center_y,
                               $signed(m_axis_tdata[63:32]));
                        errors++;
                    end
                    if (m_axis_tdata[95:64] !== want.radius)
                    begin
                        $error("radius: expected %0d, got %0d", want.radius,
                               m_axis_tdata[95:64]);
                        errors++;
                    end
                    if (m_axis_tuser[0] !== want.collinear)
                    begin
                        $error("collinear: expected %0b, got %0b", want.collinear,
                               m_axis_tuser[0]);
                        errors++;
                    end
                    if (m_axis_tuser[1] !== want.saturated)
                    begin
                        $error("saturated: expected %0b, got %0b", want.saturated,
                               m_axis_tuser[1]);
                        errors++;
                    end
                end
            end
            // Watchdog on cycles without any transfer
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_triangle(int ax, int ay, int bx, int by, int cx, int cy);
        triangles_pending.push_back({cy[15:0], cx[15:0], by[15:0], bx[15:0],
                                     ay[15:0], ax[15:0]});
    endtask

    // Hold off the sender until the pipeline has fully drained
    task automatic wait_drained();
        while (triangles_pending.size() > 0 || s_axis_tvalid
               || circles_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(logic [trc_pkg::THR_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        threshold = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random triangles: half ordinary, the rest tight, near-collinear or degenerate
    task automatic add_random(int count);
        int ax, ay, bx, by, cx, cy, k, m;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            k  = $urandom_range(0, 99);
            ax = $urandom_range(0, 65535) - 32768;
            ay = $urandom_range(0, 65535) - 32768;
            bx = $urandom_range(0, 65535) - 32768;
            by = $urandom_range(0, 65535) - 32768;
            cx = $urandom_range(0, 65535) - 32768;
            cy = $urandom_range(0, 65535) - 32768;
            if (k < 25)
            begin
                bx = ax + $urandom_range(0, 1023) - 512;
                by = ay + $urandom_range(0, 1023) - 512;
                cx = ax + $urandom_range(0, 1023) - 512;
                cy = ay + $urandom_range(0, 1023) - 512;
            end
            else if (k < 45)
            begin
                m  = $urandom_range(0, 255);
                bx = ax + $urandom_range(0, 255) - 128;
                by = ay + $urandom_range(0, 255) - 128;
                cx = ax + (bx - ax) * m / 64 + $urandom_range(0, 2) - 1;
                cy = ay + (by - ay) * m / 64 + $urandom_range(0, 2) - 1;
            end
            else if (k < 50)
            begin
                cx = bx;
                cy = by;
            end
            add_triangle(ax, ay, bx, by, cx, cy);
        end
    endtask

    initial
    begin
        logic [trc_pkg::THR_W-1:0] settings[5];
        errors    = 0;
        no_idle   = 1'b0;
        threshold = trc_pkg::THR_RESET;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, degenerate and near-degenerate triangles
        add_triangle(0, 0, 256, 0, 0, 256);
        add_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
        add_triangle(32767, 32767, -32768, 32767, 32767, -32768);
        add_triangle(-32768, 32767, 32767, 32767, 0, -32768);
        add_triangle(100, 100, 100, 100, 100, 100);
        add_triangle(-32768, -32768, -32768, -32768, -32768, -32768);
        add_triangle(32767, 32767, 32767, 32767, 32767, 32767);
        add_triangle(0, 0, 1000, 1000, 2000, 2000);
        add_triangle(-1, -1, 0, 0, 1, 1);
        add_triangle(-32768, -32768, 32767, 32766, 32766, 32765);
        add_triangle(32767, 32767, -32768, -32767, -32767, -32766);
        add_triangle(-32768, 0, 32767, 1, 32767, 0);
        add_triangle(0, 0, 1, 0, 0, 1);
        add_triangle(-2, -1, 1, 2, 0, -2);
        add_triangle(5, -7, -3, 11, 2, 2);
        add_triangle(0, 0, 0, 1, 1, 0);
        wait_drained();

        settings[0] = 16'd1;
        settings[1] = 16'd0;
        settings[2] = 16'hFFFF;
        settings[3] = 16'($urandom_range(2, 4096));
        settings[4] = 16'd2;
        foreach (settings[p])
        begin
            write_threshold(settings[p]);
            if (settings[p] == 16'd0)
            begin
                add_triangle(7, 7, 7, 7, 7, 7);
                add_triangle(0, 0, 10, 10, 20, 20);
                add_triangle(-32768, -32768, 32767, 32766, 32766, 32765);
            end
            add_random(240);
            wait_drained();
        end

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
